/* design/line_pixel_generator_core_defines.svh */
// -----------------------------------------------------------------------------
// line_pixel_generator_core_defines.svh
// Assertion macros shared by the line pixel generator checker.
// -----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lpg_pkg.sv */
// -----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the line pixel generator.
// -----------------------------------------------------------------------------
package lpg_pkg;

    // Coordinate width and derived state widths
    localparam int COORD_BITS  = 12;
    localparam int DTERM_BITS  = COORD_BITS + 3;
    localparam int COUNT_BITS  = COORD_BITS + 1;
    localparam int DTERM_PAD   = DTERM_BITS - COORD_BITS;
    localparam int COUNT_PAD   = COUNT_BITS - COORD_BITS;

    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic signed [DTERM_BITS-1:0] t_dterm;
    typedef logic [COUNT_BITS-1:0]        t_count;

    // Request codes
    typedef enum logic [0:0] {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req_type;

    // One emitted pixel
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

endpackage

/* design/lpg_req_if.sv */
// -----------------------------------------------------------------------------
// lpg_req_if
// Request channel: start a line or step to the next pixel.
// -----------------------------------------------------------------------------
interface lpg_req_if;
    import lpg_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_coord    start_x;
    t_coord    start_y;
    t_coord    end_x;
    t_coord    end_y;

    modport source (output valid, output req_type, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input req_type, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

/* design/lpg_pix_if.sv */
// -----------------------------------------------------------------------------
// lpg_pix_if
// Pixel channel: one rasterized pixel per transaction.
// -----------------------------------------------------------------------------
interface lpg_pix_if;
    import lpg_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface

/* design/line_pixel_generator_core.sv */
// -----------------------------------------------------------------------------
// line_pixel_generator_core
// Integer Bresenham line rasterizer with a start/step request interface.
// -----------------------------------------------------------------------------
// One request is taken per clock unless the output stalls, and its pixel
// appears in the output register on the next cycle, so a continuous stream of
// step requests yields one pixel every cycle. Each request is resolved in a
// single pass: a start request orders the endpoints and sets up deltas and the
// decision term, a step request advances along the major axis with one add
// and one sign test. The request side stays ready while the output register
// is empty or being taken. A step with no line in progress is consumed and
// produces no pixel; a start request abandons any line in progress.
module line_pixel_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpg_req_if.sink     i_req,
    lpg_pix_if.source   o_pix
);
    import lpg_pkg::*;

    // Line state
    t_coord r_cur_x,   n_cur_x;
    t_coord r_cur_y,   n_cur_y;
    t_dterm r_dterm,   n_dterm;
    t_count r_left,    n_left;
    t_coord r_major,   n_major;
    t_coord r_minor,   n_minor;
    logic   r_desc,    n_desc;
    logic   r_steep,   n_steep;
    logic   r_active,  n_active;

    // Output register
    logic   r_out_valid, n_out_valid;
    t_pixel r_pix,       n_pix;

    logic   req_fire;

    // Start-request setup terms
    logic   swap;
    t_coord ax, ay, bx, by, dx, dy, s_major, s_minor;
    logic   s_desc, s_steep;

    // Step-request terms
    t_coord y_next;
    t_dterm twice_major, twice_minor;
    t_count left_next;

    // Accept while the output register is free or drained this cycle
    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign req_fire    = i_req.valid && i_req.ready;

    // Order endpoints and derive deltas for a start request
    always_comb begin
        swap = (i_req.start_x > i_req.end_x) ||
               ((i_req.start_x == i_req.end_x) && (i_req.start_y > i_req.end_y));
        ax = swap ? i_req.end_x   : i_req.start_x;
        ay = swap ? i_req.end_y   : i_req.start_y;
        bx = swap ? i_req.start_x : i_req.end_x;
        by = swap ? i_req.start_y : i_req.end_y;
        dx = bx - ax;
        s_desc  = by < ay;
        dy = s_desc ? (ay - by) : (by - ay);
        s_steep = dy > dx;
        s_major = s_steep ? dy : dx;
        s_minor = s_steep ? dx : dy;
    end

    // Step terms from the stored line
    always_comb begin
        y_next      = r_desc ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
        twice_major = t_dterm'({{DTERM_PAD{1'b0}}, r_major} <<< 1);
        twice_minor = t_dterm'({{DTERM_PAD{1'b0}}, r_minor} <<< 1);
        left_next   = r_left - 1'b1;
    end

    // Next state and next output
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_dterm     = r_dterm;
        n_left      = r_left;
        n_major     = r_major;
        n_minor     = r_minor;
        n_desc      = r_desc;
        n_steep     = r_steep;
        n_active    = r_active;
        n_pix       = r_pix;
        n_out_valid = r_out_valid && !o_pix.ready;

        if (req_fire) begin
            case (i_req.req_type)
                REQ_START: begin
                    n_cur_x     = ax;
                    n_cur_y     = ay;
                    n_major     = s_major;
                    n_minor     = s_minor;
                    n_desc      = s_desc;
                    n_steep     = s_steep;
                    n_dterm     = t_dterm'({{DTERM_PAD{1'b0}}, s_minor} <<< 1)
                                - t_dterm'({{DTERM_PAD{1'b0}}, s_major});
                    n_left      = {{COUNT_PAD{1'b0}}, s_major};
                    n_active    = s_major != '0;
                    n_pix       = '{x: ax, y: ay, last: s_major == '0};
                    n_out_valid = 1'b1;
                end
                REQ_STEP: begin
                    if (r_active) begin
                        // Advance the major axis, the minor one when the term is not negative
                        if (r_steep) begin
                            n_cur_y = y_next;
                            if (!r_dterm[DTERM_BITS-1]) begin
                                n_cur_x = r_cur_x + 1'b1;
                            end
                        end else begin
                            n_cur_x = r_cur_x + 1'b1;
                            if (!r_dterm[DTERM_BITS-1]) begin
                                n_cur_y = y_next;
                            end
                        end
                        n_dterm = (r_dterm[DTERM_BITS-1] ? r_dterm : (r_dterm - twice_major))
                                + twice_minor;
                        n_left      = left_next;
                        n_active    = left_next != '0;
                        n_pix       = '{x: n_cur_x, y: n_cur_y, last: left_next == '0};
                        n_out_valid = 1'b1;
                    end
                end
                default: begin
                    n_out_valid = r_out_valid && !o_pix.ready;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_dterm     <= '0;
            r_left      <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_desc      <= 1'b0;
            r_steep     <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_dterm     <= n_dterm;
            r_left      <= n_left;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_desc      <= n_desc;
            r_steep     <= n_steep;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_pix.x;
    assign o_pix.pixel_y    = r_pix.y;
    assign o_pix.last_pixel = r_pix.last;

endmodule

/* design/lpg_checker.sv */
// -----------------------------------------------------------------------------
// lpg_checker
// Port-level checks of the line pixel generator, bound to line_pixel_generator_core.
// -----------------------------------------------------------------------------
`include "line_pixel_generator_core_defines.svh"

module lpg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input lpg_pkg::t_req_type i_req_type,
    input lpg_pkg::t_coord   i_start_x,
    input lpg_pkg::t_coord   i_start_y,
    input lpg_pkg::t_coord   i_end_x,
    input lpg_pkg::t_coord   i_end_y,
    input logic              i_pix_valid,
    input logic              i_pix_ready,
    input lpg_pkg::t_coord   i_pixel_x,
    input lpg_pkg::t_coord   i_pixel_y,
    input logic              i_last_pixel
);
    import lpg_pkg::*;

    logic req_fire;
    logic start_fire;
    logic point_fire;

    assign req_fire   = i_req_valid && i_req_ready;
    assign start_fire = req_fire && (i_req_type == REQ_START);
    assign point_fire = start_fire && (i_start_x == i_end_x) && (i_start_y == i_end_y);

    // A stalled pixel holds until taken
    `LPG_ASSERT_NEXT(a_pix_hold, i_clk, i_rst_n, i_pix_valid && !i_pix_ready, i_pix_valid && $stable(i_pixel_x) && $stable(i_pixel_y) && $stable(i_last_pixel), "pixel changed while stalled")
    // A stalled output blocks new requests
    `LPG_ASSERT_SAME(a_stall_blocks, i_clk, i_rst_n, i_pix_valid && !i_pix_ready, !i_req_ready, "request taken while output stalled")
    // Every start request yields a pixel on the next cycle
    `LPG_ASSERT_NEXT(a_start_pixel, i_clk, i_rst_n, start_fire, i_pix_valid, "start request produced no pixel")
    // A single-point line returns that point as the last pixel
    `LPG_ASSERT_NEXT(a_point_line, i_clk, i_rst_n, point_fire, i_pix_valid && i_last_pixel && (i_pixel_x == $past(i_start_x)) && (i_pixel_y == $past(i_start_y)), "single-point line wrong")

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.req_type),
    .i_start_x    (i_req.start_x),
    .i_start_y    (i_req.start_y),
    .i_end_x      (i_req.end_x),
    .i_end_y      (i_req.end_y),
    .i_pix_valid  (o_pix.valid),
    .i_pix_ready  (o_pix.ready),
    .i_pixel_x    (o_pix.pixel_x),
    .i_pixel_y    (o_pix.pixel_y),
    .i_last_pixel (o_pix.last_pixel)
);
